// ----- rtl/core/aes256_cbc_cipher_macros.svh -----
// Assertion macros for the CBC cipher core.
`ifndef AES256_CBC_CIPHER_MACROS_SVH
`define AES256_CBC_CIPHER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/aescbc_pkg.sv -----
package aescbc_pkg;

  localparam int ROUNDS = 14;
  localparam int NUM_RK = ROUNDS + 1;
  localparam int RK_AW  = $clog2(NUM_RK);
  localparam logic [RK_AW-1:0] LAST_RND = RK_AW'(ROUNDS);

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_IV_UP = 3'd4;
  localparam logic [2:0] REG_IV_LO = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_FETCH,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic dec;
    logic last_rnd;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ----- rtl/core/aes256_cbc_cipher.sv -----
// AES-256 CBC block cipher, one 128-bit block per request.
// in_*  : stream of blocks; in_tdata = {block_lower, block_upper}, in_tlast ends
//         a message, after which the chain restarts from the IV registers.
// out_* : one 128-bit result per input block, {result_lower, result_upper}.
// cfg_* : APB register port, 64-bit data, register i at byte address 8*i:
//         key words 0..3, IV upper/lower, decrypt mode. Write only while idle.
// Timing: one round per cycle through a single round unit. A block passes a
//   key fetch/load state, the round state once per round and a writeback
//   state; out_tvalid rises and in_tready returns as the state goes to idle.
// The first block after reset or after a key write first runs the key
//   schedule, one round key per cycle into the key RAM, then a fetch state.
// Reset clears the configuration registers to zero, the chain to the (zero)
//   IV and marks the round keys stale.
// A stalled receiver: the output register holds the pending result while the
//   next block is processed; that block then waits in writeback until the
//   output register frees, and no further block is taken meanwhile.
`include "aes256_cbc_cipher_macros.svh"

module aes256_cbc_cipher (
  input  logic         clk,
  input  logic         rst_n,
  // input blocks: [63:0] block_upper, [127:64] block_lower
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         in_tlast,
  // results: [63:0] result_upper, [127:64] result_lower
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = aescbc_pkg::RK_AW;

  aescbc_pkg::state_t state_r, state_nxt;

  logic [63:0]   key_r [4];
  logic [127:0]  iv_r;
  logic          mode_r;
  logic [127:0]  chain_r;
  logic          keys_ready_r;

  logic [127:0]  blk_r;
  logic          last_r;
  logic          dec_r;
  logic [127:0]  st_r;
  logic [AW-1:0] cnt_r;
  logic [7:0]    rc_r;
  logic [127:0]  ka_r, kb_r;

  logic [127:0]  rk_mem [aescbc_pkg::NUM_RK];
  logic [127:0]  rk_q_r;

  logic          out_valid_r;
  logic [127:0]  out_data_r;

  logic          in_fire, cfg_wr, out_free, rnd_last;
  logic [2:0]    cfg_idx;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [127:0]  wr_data;
  logic [127:0]  kexp_key;
  logic [127:0]  rnd_out;
  aescbc_pkg::rnd_ctl_t rnd_ctl;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign rnd_last   = dec_r ? (cnt_r == '0) : (cnt_r == aescbc_pkg::LAST_RND);
  assign rnd_ctl    = '{dec: dec_r, last_rnd: rnd_last};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[63:0], out_data_r[127:64]};

  aescbc_kexp u_kexp (
    .prev2_i (ka_r),
    .prev1_i (kb_r),
    .odd_i   (cnt_r[0]),
    .rcon_i  (rc_r),
    .key_o   (kexp_key)
  );

  aescbc_round u_round (
    .st_i  (st_r),
    .rk_i  (rk_q_r),
    .ctl_i (rnd_ctl),
    .st_o  (rnd_out)
  );

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      aescbc_pkg::REG_KEY0:  cfg_prdata = key_r[0];
      aescbc_pkg::REG_KEY1:  cfg_prdata = key_r[1];
      aescbc_pkg::REG_KEY2:  cfg_prdata = key_r[2];
      aescbc_pkg::REG_KEY3:  cfg_prdata = key_r[3];
      aescbc_pkg::REG_IV_UP: cfg_prdata = iv_r[127:64];
      aescbc_pkg::REG_IV_LO: cfg_prdata = iv_r[63:0];
      aescbc_pkg::REG_MODE:  cfg_prdata = {63'd0, mode_r};
      default:               cfg_prdata = 64'd0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aescbc_pkg::ST_IDLE:
        if (in_fire) state_nxt = keys_ready_r ? aescbc_pkg::ST_LOAD : aescbc_pkg::ST_KEXP;
      aescbc_pkg::ST_KEXP:
        if (cnt_r == aescbc_pkg::LAST_RND) state_nxt = aescbc_pkg::ST_FETCH;
      aescbc_pkg::ST_FETCH: state_nxt = aescbc_pkg::ST_LOAD;
      aescbc_pkg::ST_LOAD:  state_nxt = aescbc_pkg::ST_ROUND;
      aescbc_pkg::ST_ROUND:
        if (rnd_last) state_nxt = aescbc_pkg::ST_DONE;
      aescbc_pkg::ST_DONE:
        if (out_free) state_nxt = aescbc_pkg::ST_IDLE;
      default: state_nxt = aescbc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, key RAM read address and write port
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;
    wr_data   = kexp_key;
    unique case (state_r)
      aescbc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = mode_r ? aescbc_pkg::LAST_RND : '0;
      end
      aescbc_pkg::ST_KEXP: begin
        mem_we = 1'b1;
        if (cnt_r == AW'(0)) begin
          wr_data = ka_r;
        end else if (cnt_r == AW'(1)) begin
          wr_data = kb_r;
        end
      end
      aescbc_pkg::ST_FETCH: rd_addr = dec_r ? aescbc_pkg::LAST_RND : '0;
      aescbc_pkg::ST_LOAD:  rd_addr = dec_r ? aescbc_pkg::LAST_RND - AW'(1) : AW'(1);
      aescbc_pkg::ST_ROUND:
        if (!rnd_last) rd_addr = dec_r ? cnt_r - AW'(1) : cnt_r + AW'(1);
      aescbc_pkg::ST_DONE: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // round key RAM
  always_ff @(posedge clk) begin
    if (mem_we) rk_mem[cnt_r] <= wr_data;
    rk_q_r <= rk_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      aescbc_pkg::ST_IDLE:
        if (in_fire) begin
          blk_r  <= {in_tdata[63:0], in_tdata[127:64]};
          last_r <= in_tlast;
          dec_r  <= mode_r;
          ka_r   <= {key_r[0], key_r[1]};
          kb_r   <= {key_r[2], key_r[3]};
          rc_r   <= 8'h01;
        end
      aescbc_pkg::ST_KEXP:
        if (cnt_r > AW'(1)) begin
          ka_r <= kb_r;
          kb_r <= kexp_key;
          if (!cnt_r[0]) rc_r <= aescbc_pkg::xt(rc_r);
        end
      aescbc_pkg::ST_LOAD:
        st_r <= (dec_r ? blk_r : (blk_r ^ chain_r)) ^ rk_q_r;
      aescbc_pkg::ST_ROUND:
        st_r <= rnd_out;
      aescbc_pkg::ST_DONE:
        if (out_free) out_data_r <= dec_r ? (st_r ^ chain_r) : st_r;
      default: ;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aescbc_pkg::ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      keys_ready_r <= 1'b0;
      key_r[0]     <= 64'd0;
      key_r[1]     <= 64'd0;
      key_r[2]     <= 64'd0;
      key_r[3]     <= 64'd0;
      iv_r         <= 128'd0;
      mode_r       <= 1'b0;
      chain_r      <= 128'd0;
    end else begin
      state_r <= state_nxt;

      unique case (state_r)
        aescbc_pkg::ST_IDLE:  if (in_fire) cnt_r <= '0;
        aescbc_pkg::ST_KEXP:  cnt_r <= cnt_r + AW'(1);
        aescbc_pkg::ST_LOAD:  cnt_r <= dec_r ? aescbc_pkg::LAST_RND - AW'(1) : AW'(1);
        aescbc_pkg::ST_ROUND:
          if (!rnd_last) cnt_r <= dec_r ? cnt_r - AW'(1) : cnt_r + AW'(1);
        default: ;
      endcase

      if (state_r == aescbc_pkg::ST_KEXP && cnt_r == aescbc_pkg::LAST_RND) begin
        keys_ready_r <= 1'b1;
      end

      if (state_r == aescbc_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        // message end restarts the chain from the IV
        if (last_r) begin
          chain_r <= iv_r;
        end else begin
          chain_r <= dec_r ? blk_r : st_r;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx)
          aescbc_pkg::REG_KEY0, aescbc_pkg::REG_KEY1,
          aescbc_pkg::REG_KEY2, aescbc_pkg::REG_KEY3: begin
            key_r[cfg_idx[1:0]] <= cfg_pwdata;
            keys_ready_r        <= 1'b0;
          end
          aescbc_pkg::REG_IV_UP: begin
            iv_r[127:64] <= cfg_pwdata;
            chain_r      <= {cfg_pwdata, iv_r[63:0]};
          end
          aescbc_pkg::REG_IV_LO: begin
            iv_r[63:0] <= cfg_pwdata;
            chain_r    <= {iv_r[127:64], cfg_pwdata};
          end
          aescbc_pkg::REG_MODE: mode_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
  end

  `ASSERT_ALWAYS(a_round_has_keys, (state_r == aescbc_pkg::ST_ROUND) |-> keys_ready_r, "round without expanded keys")
  `ASSERT_NEXT(a_stale_keys_expand, in_fire && !keys_ready_r, state_r == aescbc_pkg::ST_KEXP, "stale keys not expanded")
  `ASSERT_NEXT(a_done_delivers, (state_r == aescbc_pkg::ST_DONE) && out_free, out_valid_r && (state_r == aescbc_pkg::ST_IDLE), "finished block not delivered")

endmodule

// ----- rtl/core/aescbc_kexp.sv -----
// One AES-256 key schedule step: round key r from keys r-2 and r-1.
module aescbc_kexp (
  input  logic [127:0] prev2_i,
  input  logic [127:0] prev1_i,
  input  logic         odd_i,
  input  logic [7:0]   rcon_i,
  output logic [127:0] key_o
);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {aescbc_pkg::SBOX[w[31:24]], aescbc_pkg::SBOX[w[23:16]],
                aescbc_pkg::SBOX[w[15:8]],  aescbc_pkg::SBOX[w[7:0]]};
  endfunction

  logic [31:0] t;
  logic [31:0] w0, w1, w2, w3;

  always_comb begin
    if (odd_i) begin
      t = sub_word(prev1_i[31:0]);
    end else begin
      t = sub_word({prev1_i[23:0], prev1_i[31:24]}) ^ {rcon_i, 24'h000000};
    end
    w0 = prev2_i[127:96] ^ t;
    w1 = prev2_i[95:64]  ^ w0;
    w2 = prev2_i[63:32]  ^ w1;
    w3 = prev2_i[31:0]   ^ w2;
    key_o = {w0, w1, w2, w3};
  end

endmodule

// ----- rtl/core/aescbc_round.sv -----
// One AES round, forward or inverse. Byte i is bits [127-8i -: 8],
// row i%4, column i/4.
module aescbc_round (
  input  logic [127:0]         st_i,
  input  logic [127:0]         rk_i,
  input  aescbc_pkg::rnd_ctl_t ctl_i,
  output logic [127:0]         st_o
);

  function automatic logic [7:0] mul3(input logic [7:0] a);
    mul3 = aescbc_pkg::xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    mul9 = aescbc_pkg::xt(aescbc_pkg::xt(aescbc_pkg::xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    logic [7:0] x2;
    logic [7:0] x8;
    x2 = aescbc_pkg::xt(a);
    x8 = aescbc_pkg::xt(aescbc_pkg::xt(x2));
    mul11 = x8 ^ x2 ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    logic [7:0] x4;
    logic [7:0] x8;
    x4 = aescbc_pkg::xt(aescbc_pkg::xt(a));
    x8 = aescbc_pkg::xt(x4);
    mul13 = x8 ^ x4 ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    x2 = aescbc_pkg::xt(a);
    x4 = aescbc_pkg::xt(x2);
    x8 = aescbc_pkg::xt(x4);
    mul14 = x8 ^ x4 ^ x2;
  endfunction

  always_comb begin : round_dp
    logic [7:0] s [16];
    logic [7:0] k [16];
    logic [7:0] a [16];
    logic [7:0] b [16];
    logic [7:0] o [16];
    for (int i = 0; i < 16; i++) begin
      s[i] = st_i[127-8*i -: 8];
      k[i] = rk_i[127-8*i -: 8];
      a[i] = 8'h00;
      b[i] = 8'h00;
      o[i] = 8'h00;
    end
    if (!ctl_i.dec) begin
      for (int i = 0; i < 16; i++) a[i] = aescbc_pkg::SBOX[s[i]];
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) b[4*c+r] = a[4*((c+r)&3)+r];
      end
      for (int c = 0; c < 4; c++) begin
        if (ctl_i.last_rnd) begin
          for (int r = 0; r < 4; r++) o[4*c+r] = b[4*c+r];
        end else begin
          o[4*c+0] = aescbc_pkg::xt(b[4*c]) ^ mul3(b[4*c+1]) ^ b[4*c+2] ^ b[4*c+3];
          o[4*c+1] = b[4*c] ^ aescbc_pkg::xt(b[4*c+1]) ^ mul3(b[4*c+2]) ^ b[4*c+3];
          o[4*c+2] = b[4*c] ^ b[4*c+1] ^ aescbc_pkg::xt(b[4*c+2]) ^ mul3(b[4*c+3]);
          o[4*c+3] = mul3(b[4*c]) ^ b[4*c+1] ^ b[4*c+2] ^ aescbc_pkg::xt(b[4*c+3]);
        end
      end
      for (int i = 0; i < 16; i++) o[i] = o[i] ^ k[i];
    end else begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[4*c+r] = s[4*((c-r+4)&3)+r];
      end
      for (int i = 0; i < 16; i++) b[i] = aescbc_pkg::INV_SBOX[a[i]] ^ k[i];
      for (int c = 0; c < 4; c++) begin
        if (ctl_i.last_rnd) begin
          for (int r = 0; r < 4; r++) o[4*c+r] = b[4*c+r];
        end else begin
          o[4*c+0] = mul14(b[4*c]) ^ mul11(b[4*c+1]) ^ mul13(b[4*c+2]) ^ mul9(b[4*c+3]);
          o[4*c+1] = mul9(b[4*c]) ^ mul14(b[4*c+1]) ^ mul11(b[4*c+2]) ^ mul13(b[4*c+3]);
          o[4*c+2] = mul13(b[4*c]) ^ mul9(b[4*c+1]) ^ mul14(b[4*c+2]) ^ mul11(b[4*c+3]);
          o[4*c+3] = mul11(b[4*c]) ^ mul13(b[4*c+1]) ^ mul9(b[4*c+2]) ^ mul14(b[4*c+3]);
        end
      end
    end
    for (int i = 0; i < 16; i++) st_o[127-8*i -: 8] = o[i];
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIR = 38;
  localparam int N_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_BLOCK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   reg_idx;
    logic [63:0]  upper;    // block_upper, or the register value
    logic [63:0]  lower;
    logic         last;
    logic         typed;
    logic [127:0] known;    // {result_upper, result_lower}
  } row_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [63:0] val;
  } reg_write_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;    // [63:0] block_upper, [127:64] block_lower
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // [63:0] result_upper, [127:64] result_lower
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  aes256_cbc_cipher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // cipher state mirrored by the testbench
  logic [7:0]   fwd_box [256];
  logic [7:0]   inv_box [256];
  logic [63:0]  key_reg [4] = '{default: '0};
  logic [63:0]  iv_hi = '0;
  logic [63:0]  iv_lo = '0;
  logic         mode_dec = 1'b0;
  logic [127:0] rkey [aescbc_pkg::NUM_RK];
  logic [127:0] chain = '0;
  logic         keys_valid = 1'b0;

  logic [127:0] awaited_blocks [$];
  reg_write_t   reg_batch [$];
  row_t         plan [N_DIR];
  logic [127:0] want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_dec = 0;
  int n_last = 0;
  int n_writes = 0;
  int n_results = 0;
  int n_errors = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("FAIL aes256_cbc_cipher");
    $finish;
  end

  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = dbl(a);
      b = b >> 1;
    end
    return p;
  endfunction

  // S-box from the field inverse (a^254) and the affine map
  initial begin : sbox_init
    logic [7:0] recip, sb;
    for (int a = 0; a < 256; a++) begin
      recip = 8'h01;
      for (int k = 0; k < 254; k++) recip = gmul(recip, 8'(a));
      sb = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]} ^
           {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
      fwd_box[a] = sb;
      inv_box[sb] = 8'(a);
    end
  end

  function automatic logic [31:0] sub_word32(logic [31:0] x);
    return {fwd_box[x[31:24]], fwd_box[x[23:16]], fwd_box[x[15:8]], fwd_box[x[7:0]]};
  endfunction

  // byte i of a block lives at bits [127-8i -: 8]
  function automatic logic [127:0] byte_subst(logic [127:0] s, logic inverse);
    for (int i = 0; i < 16; i++)
      s[8*(15-i) +: 8] = inverse ? inv_box[s[8*(15-i) +: 8]] : fwd_box[s[8*(15-i) +: 8]];
    return s;
  endfunction

  function automatic logic [127:0] row_rotate(logic [127:0] s, logic inverse);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inverse ? ((c - r + 4) % 4) : ((c + r) % 4);
        t[8*(15-(4*c+r)) +: 8] = s[8*(15-(4*src+r)) +: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] column_mix(logic [127:0] s, logic inverse);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [127:0] t;
    if (inverse) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[8*(15-(4*c+r)) +: 8];
      for (int r = 0; r < 4; r++)
        t[8*(15-(4*c+r)) +: 8] = gmul(m[(4-r)%4], a[0]) ^ gmul(m[(5-r)%4], a[1]) ^
                                 gmul(m[(6-r)%4], a[2]) ^ gmul(m[(7-r)%4], a[3]);
    end
    return t;
  endfunction

  // one CBC step: expands the key schedule when stale, updates the chain
  function automatic logic [127:0] cipher_block(logic [63:0] up, logic [63:0] lo, logic last);
    logic [31:0] w [4*aescbc_pkg::NUM_RK];
    logic [31:0] t;
    logic [7:0] rc;
    logic [127:0] blk, s, res;
    blk = {up, lo};
    if (!keys_valid) begin
      rc = 8'h01;
      for (int i = 0; i < 8; i++) w[i] = (i % 2) ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
      for (int i = 8; i < 4*aescbc_pkg::NUM_RK; i++) begin
        t = w[i-1];
        if (i % 8 == 0) begin
          t = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = dbl(rc);
        end else if (i % 8 == 4) begin
          t = sub_word32(t);
        end
        w[i] = w[i-8] ^ t;
      end
      for (int r = 0; r < aescbc_pkg::NUM_RK; r++)
        rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      keys_valid = 1'b1;
    end
    if (mode_dec) begin
      s = blk ^ rkey[aescbc_pkg::ROUNDS];
      for (int r = aescbc_pkg::ROUNDS - 1; r >= 0; r--) begin
        s = byte_subst(row_rotate(s, 1'b1), 1'b1) ^ rkey[r];
        if (r != 0) s = column_mix(s, 1'b1);
      end
      res = s ^ chain;
      chain = blk;
    end else begin
      s = blk ^ chain ^ rkey[0];
      for (int r = 1; r <= aescbc_pkg::ROUNDS; r++) begin
        s = row_rotate(byte_subst(s, 1'b0), 1'b0);
        if (r != aescbc_pkg::ROUNDS) s = column_mix(s, 1'b0);
        s ^= rkey[r];
      end
      res = s;
      chain = res;
    end
    if (last) chain = {iv_hi, iv_lo};
    return res;
  endfunction

  function automatic row_t blk_row(logic [63:0] up, logic [63:0] lo, logic last);
    return '{ROW_BLOCK, '0, up, lo, last, 1'b0, '0};
  endfunction

  function automatic row_t known_row(logic [63:0] up, logic [63:0] lo, logic last,
                                     logic [127:0] res);
    return '{ROW_BLOCK, '0, up, lo, last, 1'b1, res};
  endfunction

  function automatic row_t wr_row(logic [2:0] idx, logic [63:0] val);
    return '{ROW_WRITE, idx, val, '0, 1'b0, 1'b0, '0};
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (n_errors < 100) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic offer(input logic [63:0] up, input logic [63:0] lo, input logic last,
                       input logic typed, input logic [127:0] known);
    logic [127:0] pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {lo, up};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (mode_dec) n_dec++;
    if (last) n_last++;
    pred = cipher_block(up, lo, last);
    awaited_blocks.push_back(typed ? known : pred);
    n_items++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // registers change only with the block drained; writes go back to back
  task automatic apply_reg_writes();
    reg_write_t wr;
    in_tvalid <= 1'b0;
    while (awaited_blocks.size() != 0) @(posedge clk);
    while (reg_batch.size() != 0) begin
      wr = reg_batch.pop_front();
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {wr.idx, 3'b000};
      cfg_pwdata  <= wr.val;
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      n_writes++;
      case (wr.idx)
        aescbc_pkg::REG_KEY0, aescbc_pkg::REG_KEY1,
        aescbc_pkg::REG_KEY2, aescbc_pkg::REG_KEY3: begin
          key_reg[wr.idx[1:0]] = wr.val;
          keys_valid = 1'b0;
        end
        aescbc_pkg::REG_IV_UP: begin
          iv_hi = wr.val;
          chain = {iv_hi, iv_lo};
        end
        aescbc_pkg::REG_IV_LO: begin
          iv_lo = wr.val;
          chain = {iv_hi, iv_lo};
        end
        aescbc_pkg::REG_MODE: mode_dec = wr.val[0];
        default: ;
      endcase
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_blocks.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing pending", out_tdata));
        end else begin
          want = awaited_blocks.pop_front();
          if (out_tdata[63:0] !== want[127:64])
            flag_mismatch($sformatf("result %0d result_upper %h, want %h",
                                    n_results, out_tdata[63:0], want[127:64]));
          if (out_tdata[127:64] !== want[63:0])
            flag_mismatch($sformatf("result %0d result_lower %h, want %h",
                                    n_results, out_tdata[127:64], want[63:0]));
        end
        n_results++;
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] v;
    int msg_len, sent;
    plan = '{
      // zero key, zero IV straight out of reset
      known_row(64'h0, 64'h0, 1'b1, 128'hdc95c078a2408989ad48a21492842087),
      blk_row('1, '1, 1'b0),
      blk_row('1, '0, 1'b1),
      wr_row(aescbc_pkg::REG_KEY0, 64'h0001020304050607),
      wr_row(aescbc_pkg::REG_KEY1, 64'h08090a0b0c0d0e0f),
      wr_row(aescbc_pkg::REG_KEY2, 64'h1011121314151617),
      wr_row(aescbc_pkg::REG_KEY3, 64'h18191a1b1c1d1e1f),
      known_row(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
                128'h8ea2b7ca516745bfeafc49904b496089),
      wr_row(aescbc_pkg::REG_MODE, 64'h1),
      known_row(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
                128'h00112233445566778899aabbccddeeff),
      wr_row(aescbc_pkg::REG_KEY0, 64'h603deb1015ca71be),
      wr_row(aescbc_pkg::REG_KEY1, 64'h2b73aef0857d7781),
      wr_row(aescbc_pkg::REG_KEY2, 64'h1f352c073b6108d7),
      wr_row(aescbc_pkg::REG_KEY3, 64'h2d9810a30914dff4),
      wr_row(aescbc_pkg::REG_IV_UP, 64'h0001020304050607),
      wr_row(aescbc_pkg::REG_IV_LO, 64'h08090a0b0c0d0e0f),
      // only bit 0 of the mode counts: this selects encrypt
      wr_row(aescbc_pkg::REG_MODE, 64'hffff_ffff_ffff_fffe),
      known_row(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b0,
                128'hf58c4c04d6e5f1ba779eabfb5f7bfbd6),
      blk_row(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0),
      blk_row(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 1'b0),
      blk_row(64'hf69f2445df4f9b17, 64'had2b417be66c3710, 1'b1),
      wr_row(aescbc_pkg::REG_MODE, '1),
      known_row(64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6, 1'b0,
                128'h6bc1bee22e409f96e93d7e117393172a),
      blk_row(64'h9cfc4e967edb808d, 64'h679f777bc6702c7d, 1'b0),
      blk_row(64'h39f23369a9d9bacf, 64'ha530e26304231461, 1'b0),
      blk_row(64'hb2eb05e2c39be9fc, 64'hda6c19078c6a9d1b, 1'b1),
      wr_row(REG_UNUSED, 64'ha5a5_a5a5_a5a5_a5a5),
      blk_row(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0),
      // IV write in the middle of a message restarts the chain
      wr_row(aescbc_pkg::REG_IV_UP, '1),
      blk_row(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0),
      blk_row(64'h8000000000000000, 64'h0000000000000001, 1'b1),
      wr_row(aescbc_pkg::REG_MODE, '0),
      blk_row(64'h0000000000000001, 64'h8000000000000000, 1'b0),
      wr_row(aescbc_pkg::REG_IV_LO, '1),
      blk_row('1, '1, 1'b0),
      blk_row('0, '0, 1'b1),
      // one key word alone forces a new key schedule
      wr_row(aescbc_pkg::REG_KEY0, '1),
      blk_row(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_stall_pct = 35;
    for (int i = 0; i < N_DIR; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        reg_batch.push_back(reg_write_t'{plan[i].reg_idx, plan[i].upper});
      end else begin
        if (reg_batch.size() != 0) apply_reg_writes();
        offer(plan[i].upper, plan[i].lower, plan[i].last, plan[i].typed, plan[i].known);
        idle_gap();
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (ph % 2 == 0 || ph == 3 || ph == 7) begin
        for (int k = 0; k < 4; k++) begin
          v = (ph == 3) ? '0 : (ph == 7) ? '1 : {$urandom, $urandom};
          reg_batch.push_back(reg_write_t'{aescbc_pkg::REG_KEY0 + 3'(k), v});
        end
      end else if ($urandom_range(1)) begin
        reg_batch.push_back(reg_write_t'{aescbc_pkg::REG_KEY0 + 3'($urandom_range(3)),
                                         pick64()});
      end
      v = (ph == 5) ? '1 : (ph == 11) ? '0 : {$urandom, $urandom};
      reg_batch.push_back(reg_write_t'{aescbc_pkg::REG_IV_UP, v});
      v = (ph == 5) ? '1 : (ph == 11) ? '0 : {$urandom, $urandom};
      reg_batch.push_back(reg_write_t'{aescbc_pkg::REG_IV_LO, v});
      v = {$urandom, $urandom};
      v[0] = 1'(((ph / 4) % 2) ^ (ph % 2));
      reg_batch.push_back(reg_write_t'{aescbc_pkg::REG_MODE, v});
      if (ph == 12) reg_batch.push_back(reg_write_t'{REG_UNUSED, pick64()});
      apply_reg_writes();

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        msg_len = $urandom_range(1, 12);
        for (int j = 0; j < msg_len && sent < ITEMS_PER_PHASE; j++) begin
          // long receiver hold-off: the block backs up into its input
          if (ph == 4 && sent == 40) hold_req = 400;
          if (ph == 9 && sent == 50 && awaited_blocks.size() != 0) begin
            in_tvalid <= 1'b0;
            while (awaited_blocks.size() != 0) @(posedge clk);
          end
          offer(pick64(), pick64(), j == msg_len - 1, 1'b0, '0);
          sent++;
          idle_gap();
        end
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited_blocks.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_blocks.size()));
    $display("%0d blocks through the cipher (%0d decrypted, %0d ending a message),",
             n_items, n_dec, n_last);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             n_writes, n_results, n_errors);
    if (n_errors == 0) begin
      $display("PASS aes256_cbc_cipher");
    end else begin
      $display("FAIL aes256_cbc_cipher");
    end
    $finish;
  end

endmodule
